@@ hw/rtl/chm_pkg.sv @@
`timescale 1ns / 1ps
package chm_pkg;
  localparam int BUCKETS = 128;
  localparam int POOL_NODES = 256;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int LINK_W = NODE_W + 1;
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(POOL_NODES);

  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_PUT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_INC = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_HEAD  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_FREE  = 7'b0010000,
    ST_ACT   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;
endpackage

@@ hw/rtl/chained_hash_map_core.sv @@
`timescale 1ns / 1ps
// Chained hash map core. A transaction is taken when start is high and busy
// is low; exactly one result follows, shown for one cycle with done high, and
// it cannot be stalled. A transaction reads the bucket head, then walks the
// chain node by node, each node a node memory read and then a key compare.
// A put or increment of an absent key then scans the used-bit vector for the
// lowest free node, one node per cycle. Bucket heads and used bits are kept
// with per-entry valid/used flip-flops, so reset needs no clearing pass.
module chained_hash_map_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [30:0] key,
  input  logic signed [31:0] value,
  output logic        done,
  output logic signed [31:0] result_value,
  output logic        found,
  output logic        status
);
  localparam int NW = chm_pkg::NODE_W;
  localparam int LW = chm_pkg::LINK_W;
  localparam int BW = chm_pkg::BKT_W;

  // bucket heads: flop array of BUCKETS (128) entries, read at one signal address
  logic [LW-1:0] head_mem [chm_pkg::BUCKETS];
  logic [chm_pkg::BUCKETS-1:0] head_vld;
  logic [chm_pkg::KEY_W-1:0] key_mem [chm_pkg::POOL_NODES];
  logic [chm_pkg::VAL_W-1:0] val_mem [chm_pkg::POOL_NODES];
  logic [LW-1:0] link_mem [chm_pkg::POOL_NODES];
  logic [chm_pkg::POOL_NODES-1:0] used;

  chm_pkg::state_t state;
  logic [1:0] r_mode;
  logic [30:0] r_key;
  logic [31:0] r_val;
  logic [BW-1:0] bkt;
  logic [LW-1:0] cur, prev;
  logic [LW-1:0] head_q;
  logic [chm_pkg::KEY_W-1:0] nkey_q;
  logic [chm_pkg::VAL_W-1:0] nval_q;
  logic [LW-1:0] nlink_q;
  logic [LW:0] steps;
  logic [LW-1:0] scan;
  logic hit;

  // registered memory reads
  always_ff @(posedge clk) begin
    head_q <= head_vld[bkt] ? head_mem[bkt] : chm_pkg::NO_NODE;
    nkey_q <= key_mem[cur[NW-1:0]];
    nval_q <= val_mem[cur[NW-1:0]];
    nlink_q <= link_mem[cur[NW-1:0]];
  end

  logic [31:0] base, newval;
  assign base = hit ? nval_q : 32'hFFFF_FFFF;
  assign newval = (r_mode == chm_pkg::MODE_PUT) ? r_val : base + r_val;

  assign busy = (state != chm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chm_pkg::ST_IDLE;
      head_vld <= '0;
      used <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        chm_pkg::ST_IDLE: begin
          if (start) begin
            r_mode <= mode;
            r_key <= key;
            r_val <= value;
            bkt <= key[BW-1:0];
            state <= chm_pkg::ST_HEAD;
          end
        end
        chm_pkg::ST_HEAD: begin
          state <= chm_pkg::ST_RD;
        end
        chm_pkg::ST_RD: begin
          // head_q valid now; start walk
          cur <= head_q;
          prev <= chm_pkg::NO_NODE;
          steps <= '0;
          hit <= 1'b0;
          state <= (head_q[LW-1]) ? chm_pkg::ST_ACT : chm_pkg::ST_CMP;
          scan <= '0;
        end
        chm_pkg::ST_CMP: begin
          // node memory read is in flight this cycle; check next cycle
          state <= chm_pkg::ST_FREE;
        end
        chm_pkg::ST_FREE: begin
          if (nkey_q == r_key) begin
            hit <= 1'b1;
            state <= chm_pkg::ST_ACT;
          end else if (nlink_q[LW-1] || steps == (LW+1)'(chm_pkg::POOL_NODES - 1)) begin
            state <= chm_pkg::ST_ACT;
            cur <= chm_pkg::NO_NODE;
          end else begin
            prev <= cur;
            cur <= nlink_q;
            steps <= steps + 1'b1;
            state <= chm_pkg::ST_CMP;
          end
        end
        chm_pkg::ST_ACT: begin
          if (r_mode == chm_pkg::MODE_GET) begin
            result_value <= base;
            found <= hit;
            status <= 1'b0;
            state <= chm_pkg::ST_DONE;
          end else if (r_mode == chm_pkg::MODE_REMOVE) begin
            if (hit) begin
              if (!prev[LW-1]) link_mem[prev[NW-1:0]] <= nlink_q;
              else head_mem[bkt] <= nlink_q;
              used[cur[NW-1:0]] <= 1'b0;
            end
            result_value <= '0;
            found <= hit;
            status <= 1'b0;
            state <= chm_pkg::ST_DONE;
          end else if (hit) begin
            val_mem[cur[NW-1:0]] <= newval;
            result_value <= newval;
            found <= 1'b1;
            status <= 1'b0;
            state <= chm_pkg::ST_DONE;
          end else if (scan[LW-1]) begin
            result_value <= '0;
            found <= 1'b0;
            status <= 1'b1;
            state <= chm_pkg::ST_DONE;
          end else if (!used[scan[NW-1:0]]) begin
            key_mem[scan[NW-1:0]] <= r_key;
            val_mem[scan[NW-1:0]] <= newval;
            link_mem[scan[NW-1:0]] <= head_q;
            used[scan[NW-1:0]] <= 1'b1;
            head_mem[bkt] <= scan;
            head_vld[bkt] <= 1'b1;
            result_value <= newval;
            found <= 1'b0;
            status <= 1'b0;
            state <= chm_pkg::ST_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        chm_pkg::ST_DONE: begin
          done <= 1'b1;
          state <= chm_pkg::ST_IDLE;
        end
        default: state <= chm_pkg::ST_IDLE;
      endcase
      if (state == chm_pkg::ST_ACT && r_mode == chm_pkg::MODE_REMOVE && hit && prev[LW-1])
        head_vld[bkt] <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == chm_pkg::ST_HEAD)) else $error("start not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_status_nf: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!found && result_value == 0)) else $error("bad refuse");
`endif
endmodule

@@ tb/sv/chained_hash_map_checker.sv @@
`timescale 1ns / 1ps
module chained_hash_map_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode,
  input  logic [30:0]        key,
  input  logic signed [31:0] value,
  input  logic               done,
  input  logic signed [31:0] result_value,
  input  logic               found,
  input  logic               status,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    logic               status;
  } map_answer_t;

  logic [chm_pkg::LINK_W-1:0] head_q [chm_pkg::BUCKETS];
  logic [chm_pkg::KEY_W-1:0]  nkey   [chm_pkg::POOL_NODES];
  logic [chm_pkg::VAL_W-1:0]  nval   [chm_pkg::POOL_NODES];
  logic [chm_pkg::LINK_W-1:0] nlink  [chm_pkg::POOL_NODES];
  logic                       nused  [chm_pkg::POOL_NODES];
  map_answer_t                answers_due [$];

  // applies one transaction to the shadow map and returns its answer
  function automatic map_answer_t apply_map_op(logic [1:0] m, logic [30:0] k,
                                               logic [31:0] v);
    int bkt, cur, prv, hit, steps, fr;
    logic [31:0] nv;
    map_answer_t a;
    bkt = k % chm_pkg::BUCKETS;
    cur = head_q[bkt];
    prv = chm_pkg::POOL_NODES;
    hit = chm_pkg::POOL_NODES;
    steps = 0;
    while (cur < chm_pkg::POOL_NODES && steps < chm_pkg::POOL_NODES &&
           hit == chm_pkg::POOL_NODES) begin
      if (nkey[cur] == k) begin
        hit = cur;
      end else begin
        prv = cur;
        cur = nlink[cur];
        steps++;
      end
    end
    a.found = (hit < chm_pkg::POOL_NODES);
    a.status = 1'b0;
    a.result_value = '0;
    case (m)
      chm_pkg::MODE_GET: begin
        a.result_value = a.found ? nval[hit] : 32'hFFFF_FFFF;
      end
      chm_pkg::MODE_PUT, chm_pkg::MODE_INC: begin
        if (m == chm_pkg::MODE_PUT) nv = v;
        else nv = (a.found ? nval[hit] : 32'hFFFF_FFFF) + v;
        if (a.found) begin
          nval[hit] = nv;
          a.result_value = nv;
        end else begin
          fr = chm_pkg::POOL_NODES;
          for (int i = chm_pkg::POOL_NODES - 1; i >= 0; i--)
            if (!nused[i]) fr = i;
          if (fr == chm_pkg::POOL_NODES) begin
            a.status = 1'b1;   // pool full, map untouched
          end else begin
            nkey[fr] = k;
            nval[fr] = nv;
            nlink[fr] = head_q[bkt];
            nused[fr] = 1'b1;
            head_q[bkt] = chm_pkg::LINK_W'(fr);
            a.result_value = nv;
          end
        end
      end
      default: begin
        if (a.found) begin
          if (prv < chm_pkg::POOL_NODES) nlink[prv] = nlink[hit];
          else head_q[bkt] = nlink[hit];
          nused[hit] = 1'b0;
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    map_answer_t want;
    if (rst) begin
      for (int i = 0; i < chm_pkg::BUCKETS; i++) head_q[i] = chm_pkg::NO_NODE;
      for (int i = 0; i < chm_pkg::POOL_NODES; i++) nused[i] = 1'b0;
      answers_due.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result value=%0d found=%0b status=%0b",
                   $time, result_value, found, status);
          errors <= errors + 1;
        end else begin
          want = answers_due.pop_front();
          if (want.result_value !== result_value || want.found !== found ||
              want.status !== status) begin
            $display("%0t: mismatch expected %0d/%0b/%0b got %0d/%0b/%0b",
                     $time, want.result_value, want.found, want.status,
                     result_value, found, status);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) answers_due.push_back(apply_map_op(mode, key, value));
      pending <= answers_due.size();
    end
  end

endmodule

@@ tb/sv/tb_chained_hash_map_core.sv @@
`timescale 1ns / 1ps
module tb_chained_hash_map_core;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic [30:0]        key;
  logic signed [31:0] value;
  logic               done;
  logic signed [31:0] result_value;
  logic               found;
  logic               status;
  int                 errors;
  int                 pending;
  int                 idle_pct;
  logic [30:0]        hot_keys [48];

  chained_hash_map_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .key(key),
    .value(value), .done(done), .result_value(result_value), .found(found),
    .status(status)
  );

  chained_hash_map_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .key(key),
    .value(value), .done(done), .result_value(result_value), .found(found),
    .status(status), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one transaction: hold start until taken, then maybe leave a gap
  task automatic send_op(logic [1:0] m, logic [30:0] k, logic [31:0] v);
    int gap;
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly keys sharing a few buckets so chains grow; some fully random
  task automatic random_ops(int n);
    logic [30:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) k = 31'($urandom);
      else k = hot_keys[$urandom_range(47)];
      send_op(2'($urandom_range(3)), k,
              ($urandom_range(3) == 0) ? 32'($urandom_range(20)) : $urandom);
    end
  endtask

  initial begin
    start = 1'b0;
    mode  = chm_pkg::MODE_GET;
    key   = '0;
    value = '0;
    idle_pct = 0;
    rst = 1'b1;
    for (int i = 0; i < 48; i++)
      hot_keys[i] = {24'($urandom), 7'($urandom_range(7))};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: absent key handling, key and value extremes, wraparound, shared-bucket chains
    send_op(chm_pkg::MODE_GET, 31'd0, 32'd0);
    send_op(chm_pkg::MODE_REMOVE, 31'd0, 32'd0);
    send_op(chm_pkg::MODE_PUT, 31'd0, 32'h7FFF_FFFF);
    send_op(chm_pkg::MODE_GET, 31'd0, 32'hFFFF_FFFF);
    send_op(chm_pkg::MODE_INC, 31'd0, 32'd1);
    send_op(chm_pkg::MODE_GET, 31'd0, 32'd0);
    send_op(chm_pkg::MODE_INC, 31'h7FFF_FFFF, 32'h8000_0000);
    send_op(chm_pkg::MODE_INC, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(chm_pkg::MODE_PUT, 31'd128, 32'h8000_0000);
    send_op(chm_pkg::MODE_PUT, 31'd256, 32'd5);
    send_op(chm_pkg::MODE_REMOVE, 31'd128, 32'd0);
    send_op(chm_pkg::MODE_GET, 31'd128, 32'd0);
    send_op(chm_pkg::MODE_GET, 31'd256, 32'd0);
    send_op(chm_pkg::MODE_GET, 31'd0, 32'd0);
    send_op(chm_pkg::MODE_REMOVE, 31'd0, 32'd0);
    send_op(chm_pkg::MODE_INC, 31'h7FFF_FF80, 32'hFFFF_FFFF);
    send_op(chm_pkg::MODE_GET, 31'h7FFF_FFFF, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 67 : (ph == 3) ? 30 : 0;
      random_ops(160);
      if (ph == 1) begin
        // fill the pool, hit it with new and existing keys, then remove the fill keys
        for (int i = 0; i < 270; i++)
          send_op(chm_pkg::MODE_PUT, 31'h4000_0000 + 31'(i * 5), $urandom);
        random_ops(40);
        send_op(chm_pkg::MODE_INC, 31'h2AAA_AAAA, 32'd3);
        for (int i = 0; i < 270; i++)
          send_op(chm_pkg::MODE_REMOVE, 31'h4000_0000 + 31'(i * 5), 32'd0);
      end
    end
    start <= 1'b0;

    // let the checker log the last transaction before polling its count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/chm_pkg.sv
hw/rtl/chained_hash_map_core.sv
tb/sv/chained_hash_map_checker.sv
tb/sv/tb_chained_hash_map_core.sv
